@@ rtl/fpdm_pkg.sv @@
// Package: shared types and constants of the phase duty modulator.
`timescale 1ns / 1ps
package fpdm_pkg;
   localparam int ANGLE_BITS_DEFAULT = 14;
   localparam int TURN_BITS = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam int SINE_STAGES = 6;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_POLE_PAIRS = 3'd0,
      REG_REVERSE    = 3'd1,
      REG_OFFSET     = 3'd2,
      REG_CENTER     = 3'd3,
      REG_TICKS      = 3'd4,
      REG_PERIOD     = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [3:0]  pole_pairs;
      logic        reverse_direction;
      logic [13:0] angle_offset;
      logic [14:0] center_voltage;
      logic [15:0] ticks_per_volt;
      logic [11:0] pwm_period;
   } cfg_type;

   // Quarter-wave argument: Q14 fraction (0..16384) and result sign.
   typedef struct packed {
      logic [14:0] x;
      logic        neg;
   } quarter_type;

   localparam logic [14:0] QUARTER = 15'd16384;
   localparam logic [14:0] SQRT3_HALF = 15'd28378;

   // Q30 odd Taylor coefficients of sin(pi/2*x), lowest order first.
   localparam logic [30:0] SINE_COEF [0:4] = '{
      31'd1686629713, 31'd693598668, 31'd85569306, 31'd5026995, 31'd172272
   };
endpackage

@@ rtl/fpdm_angle.sv @@
// Angle front end: input beat register and electrical angle to quadrant args.
`timescale 1ns / 1ps
module fpdm_angle #(
   parameter int ANGLE_BITS = fpdm_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [ANGLE_BITS-1:0]   sensor_angle,
   input  logic signed [15:0]      q_voltage,
   input  logic signed [15:0]      d_voltage,
   input  fpdm_pkg::cfg_type       cfg,
   output logic                    out_valid,
   output fpdm_pkg::quarter_type   sin_arg,
   output fpdm_pkg::quarter_type   cos_arg,
   output logic signed [15:0]      q_out,
   output logic signed [15:0]      d_out
);
   localparam int WW = ANGLE_BITS + 14;
   localparam int TB = fpdm_pkg::TURN_BITS;

   logic                  valid1_ff, valid2_ff;
   logic [ANGLE_BITS-1:0] sensor_ff;
   logic signed [15:0]    q1_ff, d1_ff, q2_ff, d2_ff;
   fpdm_pkg::quarter_type sin_ff, cos_ff, sin_in, cos_in;
   logic [WW-1:0]         prod_w, diff_w;
   logic [ANGLE_BITS-1:0] elec;
   logic [TB-1:0]         turn, cos_turn;

   function automatic fpdm_pkg::quarter_type quarter_of(input logic [15:0] t);
      fpdm_pkg::quarter_type r;
      r.neg = t[15];
      r.x   = t[14] ? (fpdm_pkg::QUARTER - {1'b0, t[13:0]}) : {1'b0, t[13:0]};
      return r;
   endfunction

   always_comb begin
      prod_w = WW'(cfg.pole_pairs) * WW'(sensor_ff);
      if (cfg.reverse_direction) begin
         prod_w = -prod_w;
      end
      diff_w   = prod_w - WW'(cfg.angle_offset);
      elec     = diff_w[ANGLE_BITS-1:0];
      turn     = TB'(elec) << (TB - ANGLE_BITS);
      cos_turn = turn + TB'(16'h4000);
      sin_in   = quarter_of(turn);
      cos_in   = quarter_of(cos_turn);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
      sensor_ff <= sensor_angle;
      q1_ff     <= q_voltage;
      d1_ff     <= d_voltage;
      sin_ff    <= sin_in;
      cos_ff    <= cos_in;
      q2_ff     <= q1_ff;
      d2_ff     <= d1_ff;
   end

   assign out_valid = valid2_ff;
   assign sin_arg   = sin_ff;
   assign cos_arg   = cos_ff;
   assign q_out     = q2_ff;
   assign d_out     = d2_ff;
endmodule

@@ rtl/fpdm_sine.sv @@
// Pipelined quarter-wave sine: squaring stage, one Horner step per middle stage, rounding stage, Q1.15 signed result.
`timescale 1ns / 1ps
module fpdm_sine (
   input  logic                  clock,
   input  fpdm_pkg::quarter_type arg,
   output logic signed [15:0]    sine
);
   logic [30:0]        x2_ff [0:4];
   logic [14:0]        x_ff  [0:4];
   logic               neg_ff[0:4];
   logic [30:0]        p_ff  [0:4];
   logic [30:0]        p_in  [1:4];
   logic [61:0]        m     [1:4];
   logic [30:0]        xx;
   logic [61:0]        sm;
   logic [31:0]        s32;
   logic [32:0]        rnd;
   logic [14:0]        mag;
   logic signed [15:0] sine_ff, sine_in;

   // Square the argument: x2 = (x*2^16)^2 / 2^30 = 4*x^2.
   // Seed the Horner chain with the highest-order coefficient.
   always_ff @(posedge clock) begin
      x2_ff[0]  <= {31'(arg.x) * 31'(arg.x)} << 2;
      x_ff[0]   <= arg.x;
      neg_ff[0] <= arg.neg;
      p_ff[0]   <= fpdm_pkg::SINE_COEF[4];
   end

   for (genvar k = 1; k <= 4; k++) begin : g_horner
      always_comb begin
         m[k]    = 62'(x2_ff[k-1]) * 62'(p_ff[k-1]);
         p_in[k] = fpdm_pkg::SINE_COEF[4-k] - 31'(m[k] >> 30);
      end
      always_ff @(posedge clock) begin
         p_ff[k]   <= p_in[k];
         x2_ff[k]  <= x2_ff[k-1];
         x_ff[k]   <= x_ff[k-1];
         neg_ff[k] <= neg_ff[k-1];
      end
   end

   // Final multiply by x, round half up to Q15, clamp, apply sign.
   always_comb begin
      xx  = {x_ff[4], 16'b0};
      sm  = 62'(xx) * 62'(p_ff[4]);
      s32 = 32'(sm >> 30);
      rnd = (33'(s32) + 33'd16384) >> 15;
      mag = (rnd > 33'd32767) ? 15'd32767 : rnd[14:0];
      sine_in = neg_ff[4] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

   always_ff @(posedge clock) begin
      sine_ff <= sine_in;
   end

   assign sine = sine_ff;
endmodule

@@ rtl/fpdm_drive.sv @@
// Inverse Park and Clarke, tick scaling and duty clamp, four stages.
`timescale 1ns / 1ps
module fpdm_drive (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic signed [15:0] sin_val,
   input  logic signed [15:0] cos_val,
   input  logic signed [15:0] q_voltage,
   input  logic signed [15:0] d_voltage,
   input  fpdm_pkg::cfg_type  cfg,
   output logic               out_valid,
   output logic [11:0]        duty_a,
   output logic [11:0]        duty_b,
   output logic [11:0]        duty_c
);
   logic [3:0]         valid_ff;
   logic signed [32:0] alpha_ff, beta_ff;
   logic signed [31:0] cd, sq, sd, cq;
   logic signed [49:0] a_w, kb, ctr;
   logic signed [49:0] ph_ff [0:2];
   logic signed [49:0] ph_in [0:2];
   logic signed [66:0] tw;
   logic signed [66:0] tp    [0:2];
   logic signed [16:0] hi_ff [0:2];
   logic [11:0]        duty_ff [0:2];
   logic [11:0]        duty_in [0:2];

   always_comb begin
      cd = sin_val * 16'sd0 + cos_val * d_voltage;
      sq = sin_val * q_voltage;
      sd = sin_val * d_voltage;
      cq = cos_val * q_voltage;
   end

   always_comb begin
      a_w = 50'(alpha_ff);
      kb  = 50'(beta_ff) * 50'($signed({1'b0, fpdm_pkg::SQRT3_HALF}));
      ctr = $signed({5'b0, cfg.center_voltage, 30'b0});
      ph_in[0] = (a_w <<< 15) + ctr;
      ph_in[1] = ctr - (a_w <<< 14) + kb;
      ph_in[2] = ctr - (a_w <<< 14) - kb;
      tw = $signed({51'b0, cfg.ticks_per_volt});
   end

   for (genvar i = 0; i < 3; i++) begin : g_phase
      always_comb begin
         tp[i] = 67'(ph_ff[i]) * tw;
         // Negative ticks drop to zero, above period clamp to period.
         if (hi_ff[i][16]) begin
            duty_in[i] = 12'd0;
         end else if (hi_ff[i][15:0] > {4'b0, cfg.pwm_period}) begin
            duty_in[i] = cfg.pwm_period;
         end else begin
            duty_in[i] = hi_ff[i][11:0];
         end
      end
      always_ff @(posedge clock) begin
         ph_ff[i]   <= ph_in[i];
         hi_ff[i]   <= tp[i][66:50];
         duty_ff[i] <= duty_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
      alpha_ff <= 33'(cd) - 33'(sq);
      beta_ff  <= 33'(sd) + 33'(cq);
   end

   assign out_valid = valid_ff[3];
   assign duty_a    = duty_ff[0];
   assign duty_b    = duty_ff[1];
   assign duty_c    = duty_ff[2];
endmodule

@@ rtl/foc_phase_duty_modulator_unit.sv @@
// Top level: phase duty modulator, inverse Park/Clarke with sinusoidal PWM.
// Usage:
//   Present a sensor angle and q/d voltage commands with start high; a beat
//   is taken at every clock edge where start is high and busy is low. busy
//   is always low, so a new beat may enter in every cycle.
//   Each beat yields one result: rsp_valid pulses for one cycle with the
//   three phase compare values, once the beat has passed the whole pipeline.
//   Throughput is one beat per clock. The pipeline has 2 angle stages,
//   6 sine stages (square, Horner steps, round) and
//   4 drive stages (Park, Clarke, tick multiply, clamp).
//   The receiver cannot stall; results are strobed out and never held.
//   Registers are written on csr_ (csr_ready always high); the user must do so
//   while no beat is in flight, unenforced; indexes past the list are ignored.
//   Reset clears the pipeline valid bits and loads register defaults:
//   7 pole pairs, reverse on, offset 0, center 10240, gain 25600, period 500.
`timescale 1ns / 1ps
module foc_phase_duty_modulator_unit #(
   parameter int ANGLE_BITS = fpdm_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [ANGLE_BITS-1:0]               req_sensor_angle,
   input  logic signed [15:0]                  req_q_voltage,
   input  logic signed [15:0]                  req_d_voltage,
   output logic                                rsp_valid,
   output logic [11:0]                         rsp_duty_a,
   output logic [11:0]                         rsp_duty_b,
   output logic [11:0]                         rsp_duty_c,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fpdm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [fpdm_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   localparam int SL = fpdm_pkg::SINE_STAGES;

   fpdm_pkg::cfg_type     cfg_ff;
   fpdm_pkg::quarter_type sin_arg, cos_arg;
   logic                  ang_valid;
   logic signed [15:0]    ang_q, ang_d;
   logic signed [15:0]    sin_val, cos_val;
   logic                  vdly_ff [0:SL-1];
   logic signed [15:0]    qdly_ff [0:SL-1];
   logic signed [15:0]    ddly_ff [0:SL-1];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Register file: mask each write to the register width.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pole_pairs        <= 4'd7;
         cfg_ff.reverse_direction <= 1'b1;
         cfg_ff.angle_offset      <= 14'd0;
         cfg_ff.center_voltage    <= 15'd10240;
         cfg_ff.ticks_per_volt    <= 16'd25600;
         cfg_ff.pwm_period        <= 12'd500;
      end else if (csr_valid) begin
         case (csr_index)
            fpdm_pkg::REG_POLE_PAIRS: cfg_ff.pole_pairs        <= csr_data[3:0];
            fpdm_pkg::REG_REVERSE:    cfg_ff.reverse_direction <= csr_data[0];
            fpdm_pkg::REG_OFFSET:     cfg_ff.angle_offset      <= csr_data[13:0];
            fpdm_pkg::REG_CENTER:     cfg_ff.center_voltage    <= csr_data[14:0];
            fpdm_pkg::REG_TICKS:      cfg_ff.ticks_per_volt    <= csr_data;
            fpdm_pkg::REG_PERIOD:     cfg_ff.pwm_period        <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   fpdm_angle #(.ANGLE_BITS(ANGLE_BITS)) u_angle (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (start && !busy),
      .sensor_angle (req_sensor_angle),
      .q_voltage    (req_q_voltage),
      .d_voltage    (req_d_voltage),
      .cfg          (cfg_ff),
      .out_valid    (ang_valid),
      .sin_arg      (sin_arg),
      .cos_arg      (cos_arg),
      .q_out        (ang_q),
      .d_out        (ang_d)
   );

   fpdm_sine u_sin (.clock(clock), .arg(sin_arg), .sine(sin_val));
   fpdm_sine u_cos (.clock(clock), .arg(cos_arg), .sine(cos_val));

   // Hold valid and the voltage commands alongside the sine pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SL; i++) begin
            vdly_ff[i] <= 1'b0;
         end
      end else begin
         vdly_ff[0] <= ang_valid;
         for (int i = 1; i < SL; i++) begin
            vdly_ff[i] <= vdly_ff[i-1];
         end
      end
      qdly_ff[0] <= ang_q;
      ddly_ff[0] <= ang_d;
      for (int i = 1; i < SL; i++) begin
         qdly_ff[i] <= qdly_ff[i-1];
         ddly_ff[i] <= ddly_ff[i-1];
      end
   end

   fpdm_drive u_drive (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vdly_ff[SL-1]),
      .sin_val   (sin_val),
      .cos_val   (cos_val),
      .q_voltage (qdly_ff[SL-1]),
      .d_voltage (ddly_ff[SL-1]),
      .cfg       (cfg_ff),
      .out_valid (rsp_valid),
      .duty_a    (rsp_duty_a),
      .duty_b    (rsp_duty_b),
      .duty_c    (rsp_duty_c)
   );
endmodule
